[src/sma_pkg.sv]
// ----------------------------------------------------------------------------
// sma_pkg
// Shared widths, reset values and controller/datapath interface types
// for the moving average block.
// ----------------------------------------------------------------------------
package sma_pkg;

	localparam int SAMPLE_W = 24;
	localparam int WLEN_W   = 7;
	localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd8;

	typedef struct packed {
		logic load;
		logic read;
		logic accum;
		logic div_start;
		logic out_load;
	} sma_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic out_free;
	} sma_stat_t;

endpackage

[src/sma_div.sv]
// ----------------------------------------------------------------------------
// sma_div
// Bit-serial signed by unsigned divider, one quotient bit per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module sma_div
	import sma_pkg::*;
#(
	parameter int SUM_W = 30,
	parameter int LEN_W = 7
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [SUM_W-1:0]    dividend,
	input  logic        [LEN_W-1:0]    divisor,
	output logic                       busy,
	output logic signed [SAMPLE_W-1:0] quotient
);

	localparam int CNT_W = $clog2(SUM_W);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0] mag_q;
	logic [LEN_W-1:0] rem_q;
	logic [LEN_W-1:0] div_q;
	logic             neg_q;
	logic [LEN_W:0]   trial;
	logic             fits;
	logic [SUM_W-1:0] quot_signed;

	assign trial = {rem_q, mag_q[SUM_W-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(SUM_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
			neg_q <= dividend[SUM_W-1];
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= LEN_W'(trial - {1'b0, div_q});
			end else begin
				rem_q <= trial[LEN_W-1:0];
			end
			mag_q <= {mag_q[SUM_W-2:0], fits};
		end
	end

	assign quot_signed = neg_q ? (~mag_q + 1'b1) : mag_q;
	assign quotient    = quot_signed[SAMPLE_W-1:0];
	assign busy        = busy_q;

endmodule

[src/sma_datapath.sv]
// ----------------------------------------------------------------------------
// sma_datapath
// Sample ring, running sum, fill count, divider and output register.
// ----------------------------------------------------------------------------
module sma_datapath
	import sma_pkg::*;
#(
	parameter int MAX_WINDOW = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sma_cmd_t            cmd,
	output sma_stat_t           stat,
	input  logic [SAMPLE_W-1:0] in_sample,
	input  logic                in_start,
	input  logic                cfg_write,
	input  logic [WLEN_W-1:0]   cfg_data,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [SAMPLE_W-1:0] out_average,
	output logic                out_average_valid
);

	localparam int EFF_MAX = (MAX_WINDOW < 127) ? MAX_WINDOW : 127;
	localparam int LEN_W   = $clog2(EFF_MAX + 1);
	localparam int SUM_W   = SAMPLE_W + $clog2(EFF_MAX);
	localparam int AW      = $clog2(MAX_WINDOW);
	localparam int OW      = AW + 1;
	localparam int CW      = (WLEN_W > OW) ? WLEN_W : OW;

	logic [SAMPLE_W-1:0] ring_mem [MAX_WINDOW];

	logic [WLEN_W-1:0]       wlen_q;
	logic [LEN_W-1:0]        len;
	logic [SAMPLE_W-1:0]     sample_q;
	logic [SAMPLE_W-1:0]     old_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [AW-1:0]           wp_q;
	logic [LEN_W-1:0]        fill_q;
	logic                    valid_q;
	logic                    full;
	logic [OW-1:0]           wp_x;
	logic [OW-1:0]           len_x;
	logic [OW-1:0]           old_x;
	logic [AW-1:0]           old_addr;
	logic signed [SUM_W-1:0] sample_ext;
	logic signed [SUM_W-1:0] old_ext;
	logic                    div_busy;
	logic [SAMPLE_W-1:0]     quotient;
	logic                    out_valid_q;
	logic [SAMPLE_W-1:0]     avg_q;
	logic                    avg_valid_q;

	// effective window length, zero taken as one, clamped to ring depth
	always_comb begin
		if (wlen_q == '0) begin
			len = LEN_W'(1);
		end else if (CW'(wlen_q) > CW'(MAX_WINDOW)) begin
			len = LEN_W'(MAX_WINDOW);
		end else begin
			len = LEN_W'(wlen_q);
		end
	end

	assign full  = fill_q >= len;
	assign wp_x  = OW'(wp_q);
	assign len_x = OW'(len);

	always_comb begin
		if (wp_x >= len_x) begin
			old_x = wp_x - len_x;
		end else begin
			old_x = wp_x + OW'(MAX_WINDOW) - len_x;
		end
	end

	assign old_addr   = old_x[AW-1:0];
	assign sample_ext = {{(SUM_W-SAMPLE_W){sample_q[SAMPLE_W-1]}}, sample_q};
	assign old_ext    = full ? {{(SUM_W-SAMPLE_W){old_q[SAMPLE_W-1]}}, old_q} : '0;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_q <= in_sample;
		end
		if (cmd.read) begin
			old_q          <= ring_mem[old_addr];
			ring_mem[wp_q] <= sample_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q  <= WLEN_RESET;
			sum_q   <= '0;
			wp_q    <= '0;
			fill_q  <= '0;
			valid_q <= 1'b0;
		end else if (cfg_write) begin
			wlen_q <= cfg_data;
			sum_q  <= '0;
			wp_q   <= '0;
			fill_q <= '0;
		end else if (cmd.load && in_start) begin
			sum_q  <= '0;
			wp_q   <= '0;
			fill_q <= '0;
		end else if (cmd.accum) begin
			sum_q   <= sum_q - old_ext + sample_ext;
			wp_q    <= (wp_q == AW'(MAX_WINDOW - 1)) ? '0 : wp_q + 1'b1;
			fill_q  <= full ? fill_q : fill_q + 1'b1;
			valid_q <= full || ((fill_q + 1'b1) == len);
		end
	end

	sma_div #(
		.SUM_W (SUM_W),
		.LEN_W (LEN_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sum_q),
		.divisor  (len),
		.busy     (div_busy),
		.quotient (quotient)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			avg_q       <= valid_q ? quotient : '0;
			avg_valid_q <= valid_q;
		end
	end

	assign out_valid         = out_valid_q;
	assign out_average       = avg_q;
	assign out_average_valid = avg_valid_q;

	assign stat.div_busy = div_busy;
	assign stat.out_free = !out_valid_q || out_ready;

endmodule

[src/sma_ctrl.sv]
// ----------------------------------------------------------------------------
// sma_ctrl
// Sequencer for one request: ring access, sum update, division and
// hand-off to the output register.
// ----------------------------------------------------------------------------
module sma_ctrl
	import sma_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  sma_stat_t stat,
	output sma_cmd_t  cmd
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_READ   = 6'b000010,
		ST_ACCUM  = 6'b000100,
		ST_DSTART = 6'b001000,
		ST_DIV    = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_READ;
				end
			end
			ST_READ: begin
				cmd.read  = 1'b1;
				state_nxt = ST_ACCUM;
			end
			ST_ACCUM: begin
				cmd.accum = 1'b1;
				state_nxt = ST_DSTART;
			end
			ST_DSTART: begin
				cmd.div_start = 1'b1;
				state_nxt     = ST_DIV;
			end
			ST_DIV: begin
				if (!stat.div_busy) begin
					state_nxt = ST_DONE;
				end
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

[src/simple_moving_average.sv]
// ----------------------------------------------------------------------------
// simple_moving_average
// Boxcar moving average over a programmable window of signed samples.
//
// Input stream s_axis: one sample per request, tuser flags the first sample
// of a new series. Output stream m_axis: one result per sample, the window
// average truncated toward zero, tuser set once the window has filled.
// cfg: write of window_length; it also restarts the current series.
// Lengths of zero read as one, lengths above MAX_WINDOW as MAX_WINDOW.
//
// A sample is registered, then passes through the ring read, the sum update
// and the bit-serial divider, which retires one quotient bit per cycle, into
// the output register that drives m_axis. A new request is taken only once
// the last result is handed to the output register.
// The sample ring is a memory with one read and one write port inside the
// datapath, touched once per request.
//
// Reset clears the sum, fill count and write pointer and loads a window of
// 8; the ring needs no clearing. When the receiver stalls, the finished
// result waits in the output register while the next sample is taken and
// processed; it then holds until the register frees.
// ----------------------------------------------------------------------------
module simple_moving_average
	import sma_pkg::*;
#(
	parameter int MAX_WINDOW = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [23:0]         s_axis_tdata,  // [23:0] sample
	input  logic                s_axis_tuser,  // [0] series_start
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [23:0]         m_axis_tdata,  // [23:0] average
	output logic                m_axis_tuser,  // [0] average_valid
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [WLEN_W-1:0]   cfg_data
);

	sma_cmd_t  cmd;
	sma_stat_t stat;

	assign cfg_ready = 1'b1;

	sma_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	sma_datapath #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.in_sample         (s_axis_tdata),
		.in_start          (s_axis_tuser),
		.cfg_write         (cfg_valid && cfg_ready),
		.cfg_data          (cfg_data),
		.out_valid         (m_axis_tvalid),
		.out_ready         (m_axis_tready),
		.out_average       (m_axis_tdata),
		.out_average_valid (m_axis_tuser)
	);

	// results before the window fills carry a zero average
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
		else $error("unfilled window result with nonzero average");

	// one request at a time
	a_single_request: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while a request is in flight");

	// no sample taken while the divider runs
	a_div_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_busy |-> !s_axis_tready)
		else $error("input ready during division");

	// a result is loaded only into a free output register
	a_out_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> stat.out_free)
		else $error("output register overwritten");

endmodule
